// ===== design/dqs_pkg.sv =====
package dqs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int STACK_DEPTH = 64;
  localparam int KEY_W       = 16;
  localparam int TAG_W       = 16;
  localparam int REC_W       = KEY_W + TAG_W;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SADDR_W     = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Request from the sequencer to the range stack. Push and pop are never
  // raised together; clear empties the stack at the end of a set.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } dqs_stack_req_t;

  // Stack status and the range read by the last pop.
  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } dqs_stack_rsp_t;

endpackage

// ===== design/dqs_range_stack.sv =====
module dqs_range_stack (
  input  logic                    clk,
  input  logic                    rst,
  input  dqs_pkg::dqs_stack_req_t req,
  output dqs_pkg::dqs_stack_rsp_t rsp
);

  logic [2*dqs_pkg::IDX_W-1:0]   mem [dqs_pkg::STACK_DEPTH];
  logic [2*dqs_pkg::IDX_W-1:0]   rdata;
  logic [dqs_pkg::SP_W-1:0]      sp;
  logic [dqs_pkg::SP_W-1:0]      sp_dec;

  assign sp_dec = sp - 1'b1;

  // Pointer: a push beyond the depth is dropped.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      sp <= '0;
    end else if (req.push && (sp < dqs_pkg::SP_W'(dqs_pkg::STACK_DEPTH))) begin
      sp <= sp + 1'b1;
    end else if (req.pop && (sp != '0)) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && (sp < dqs_pkg::SP_W'(dqs_pkg::STACK_DEPTH))) begin
      mem[sp[dqs_pkg::SADDR_W-1:0]] <= {req.lo, req.hi};
    end
    if (req.pop) begin
      rdata <= mem[sp_dec[dqs_pkg::SADDR_W-1:0]];
    end
  end

  assign rsp.empty = (sp == '0);
  assign rsp.lo    = rdata[2*dqs_pkg::IDX_W-1:dqs_pkg::IDX_W];
  assign rsp.hi    = rdata[dqs_pkg::IDX_W-1:0];

endmodule

// ===== design/descending_quicksort_engine.sv =====
// Each record request is taken while idle; the final one starts a Lomuto sort that scans every
// element of a range, adds SWAP_A and SWAP_B per swap, and passes POP, RANGE, PIVOT, FIN_A,
// FIN_B and PUSH_L per partitioned range and POP and RANGE per skipped one. Records
// then go out one per cycle, the first once EMIT is entered and the output registers load; busy
// stays low while loading, so records may come back to back; a new set may start after EMIT.
// rst (synchronous) clears the sequencer, record count, stack pointer and strobe, not memory.
module descending_quicksort_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [dqs_pkg::KEY_W-1:0] frequency,
  input  logic [dqs_pkg::TAG_W-1:0] tag,
  input  logic                      final_record,
  output logic                      strobe,
  output logic [dqs_pkg::KEY_W-1:0] sorted_frequency,
  output logic [dqs_pkg::TAG_W-1:0] sorted_tag,
  output logic                      end_of_run
);

  // One-hot sequencer states.
  //   IDLE   : take requests and store records.
  //   POP    : pop the next range, or go emit when the stack is empty.
  //   RANGE  : popped range is visible; skip it if trivial, else read its pivot.
  //   PIVOT  : latch the pivot, start scanning at lo.
  //   SCAN   : compare element j against the pivot.
  //   SWAP_A : write the element at next into place j.
  //   SWAP_B : write the scanned element into place next.
  //   FIN_A  : move the element at next to hi.
  //   FIN_B  : drop the pivot at next, push the right part.
  //   PUSH_L : push the left part.
  //   EMIT   : stream the sorted records out.
  // Results cannot be stalled: strobe marks each one for exactly one cycle.
  typedef enum logic [10:0] {
    IDLE   = 11'b000_0000_0001,
    POP    = 11'b000_0000_0010,
    RANGE  = 11'b000_0000_0100,
    PIVOT  = 11'b000_0000_1000,
    SCAN   = 11'b000_0001_0000,
    SWAP_A = 11'b000_0010_0000,
    SWAP_B = 11'b000_0100_0000,
    FIN_A  = 11'b000_1000_0000,
    FIN_B  = 11'b001_0000_0000,
    PUSH_L = 11'b010_0000_0000,
    EMIT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Record memory: key in the upper half, tag in the lower half.
  logic [dqs_pkg::REC_W-1:0] rec_mem [dqs_pkg::MAX_RECORDS];
  logic [dqs_pkg::REC_W-1:0] rdata;
  logic [dqs_pkg::IDX_W-1:0] raddr;
  logic                      we;
  logic [dqs_pkg::IDX_W-1:0] waddr;
  logic [dqs_pkg::REC_W-1:0] wdata;

  logic [dqs_pkg::CNT_W-1:0] count;
  logic [dqs_pkg::CNT_W-1:0] count_next;
  logic [dqs_pkg::IDX_W-1:0] lo;
  logic [dqs_pkg::IDX_W-1:0] hi;
  logic [dqs_pkg::IDX_W-1:0] j;
  logic [dqs_pkg::IDX_W-1:0] nxt;
  logic [dqs_pkg::IDX_W-1:0] k;
  logic [dqs_pkg::REC_W-1:0] pivot;
  logic [dqs_pkg::REC_W-1:0] cur;

  dqs_pkg::dqs_stack_req_t stack_req;
  dqs_pkg::dqs_stack_rsp_t stack_rsp;

  logic accept;
  logic has_room;
  logic take;
  logic range_skip;
  logic last_out;
  logic push_right;
  logic push_left;

  assign busy     = (state != IDLE);
  assign accept   = start && (state == IDLE);
  assign has_room = (count < dqs_pkg::CNT_W'(dqs_pkg::MAX_RECORDS));

  // A full store drops the incoming record but still counts the set as is.
  assign count_next = has_room ? (count + 1'b1) : count;

  // Element j joins the left group when its key is at least the pivot key.
  assign take = (rdata[dqs_pkg::REC_W-1:dqs_pkg::TAG_W] >=
                 pivot[dqs_pkg::REC_W-1:dqs_pkg::TAG_W]);

  // A popped range is skipped when it holds one element or lies past the set.
  assign range_skip = (stack_rsp.lo >= stack_rsp.hi) ||
                      (dqs_pkg::CNT_W'(stack_rsp.hi) >= count);

  assign push_right = ((dqs_pkg::CNT_W'(nxt) + 1'b1) < dqs_pkg::CNT_W'(hi));
  assign push_left  = (dqs_pkg::CNT_W'(nxt) > (dqs_pkg::CNT_W'(lo) + 1'b1));
  assign last_out   = ((dqs_pkg::CNT_W'(k) + 1'b1) == count);

  // Record memory read address: always the element needed in the next cycle.
  always_comb begin
    unique case (state)
      RANGE:   raddr = stack_rsp.hi;
      PIVOT:   raddr = lo;
      SCAN:    raddr = ((j == hi) || take) ? nxt : (j + 1'b1);
      SWAP_B:  raddr = j + 1'b1;
      EMIT:    raddr = k + 1'b1;
      default: raddr = '0;
    endcase
  end

  // Record memory write port: loading, the two halves of a swap, and the pivot move.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (state)
      IDLE: begin
        we    = accept && has_room;
        waddr = count[dqs_pkg::IDX_W-1:0];
        wdata = {frequency, tag};
      end
      SWAP_A: begin
        we    = 1'b1;
        waddr = j;
      end
      SWAP_B: begin
        we    = 1'b1;
        waddr = nxt;
        wdata = cur;
      end
      FIN_A: begin
        we    = 1'b1;
        waddr = hi;
      end
      FIN_B: begin
        we    = 1'b1;
        waddr = nxt;
        wdata = pivot;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      rec_mem[waddr] <= wdata;
    end
    rdata <= rec_mem[raddr];
  end

  // Range stack requests.
  always_comb begin
    stack_req = '0;
    unique case (state)
      IDLE: begin
        // The whole set is the first range when it holds two or more records.
        stack_req.push = accept && final_record && (count_next > dqs_pkg::CNT_W'(1));
        stack_req.lo   = '0;
        stack_req.hi   = dqs_pkg::IDX_W'(count_next - 1'b1);
      end
      POP: begin
        stack_req.pop = !stack_rsp.empty;
      end
      FIN_B: begin
        stack_req.push = push_right;
        stack_req.lo   = nxt + 1'b1;
        stack_req.hi   = hi;
      end
      PUSH_L: begin
        stack_req.push = push_left;
        stack_req.lo   = lo;
        stack_req.hi   = nxt - 1'b1;
      end
      EMIT: begin
        stack_req.clear = last_out;
      end
      default: begin
        stack_req = '0;
      end
    endcase
  end

  dqs_range_stack u_stack (
    .clk (clk),
    .rst (rst),
    .req (stack_req),
    .rsp (stack_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:    state_next = (accept && final_record) ? POP : IDLE;
      POP:     state_next = stack_rsp.empty ? EMIT : RANGE;
      RANGE:   state_next = range_skip ? POP : PIVOT;
      PIVOT:   state_next = SCAN;
      SCAN: begin
        if (j == hi) begin
          state_next = FIN_A;
        end else if (take) begin
          state_next = SWAP_A;
        end else begin
          state_next = SCAN;
        end
      end
      SWAP_A:  state_next = SWAP_B;
      SWAP_B:  state_next = SCAN;
      FIN_A:   state_next = FIN_B;
      FIN_B:   state_next = PUSH_L;
      PUSH_L:  state_next = POP;
      EMIT:    state_next = last_out ? IDLE : EMIT;
      default: state_next = IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == EMIT);
      if (accept) begin
        count <= count_next;
      end else if ((state == EMIT) && last_out) begin
        count <= '0;
      end
    end
  end

  // Partition indexes, pivot and output registers.
  always_ff @(posedge clk) begin
    unique case (state)
      POP: begin
        k <= '0;
      end
      RANGE: begin
        lo <= stack_rsp.lo;
        hi <= stack_rsp.hi;
      end
      PIVOT: begin
        pivot <= rdata;
        j     <= lo;
        nxt   <= lo;
      end
      SCAN: begin
        if ((j != hi) && take) begin
          cur <= rdata;
        end else if (j != hi) begin
          j <= j + 1'b1;
        end
      end
      SWAP_B: begin
        j   <= j + 1'b1;
        nxt <= nxt + 1'b1;
      end
      EMIT: begin
        k                <= k + 1'b1;
        sorted_frequency <= rdata[dqs_pkg::REC_W-1:dqs_pkg::TAG_W];
        sorted_tag       <= rdata[dqs_pkg::TAG_W-1:0];
        end_of_run       <= last_out;
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

// ===== bench/dqs_sort_checker.sv =====
`timescale 1ns / 100ps

module dqs_sort_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [dqs_pkg::KEY_W-1:0] frequency,
  input  logic [dqs_pkg::TAG_W-1:0] tag,
  input  logic                      final_record,
  input  logic                      strobe,
  input  logic [dqs_pkg::KEY_W-1:0] sorted_frequency,
  input  logic [dqs_pkg::TAG_W-1:0] sorted_tag,
  input  logic                      end_of_run,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic [dqs_pkg::KEY_W-1:0] freq;
    logic [dqs_pkg::TAG_W-1:0] id;
    logic                      last;
  } sorted_record_t;

  // Local copy of the record memory and the range stack.
  logic [dqs_pkg::KEY_W-1:0]   held_key [dqs_pkg::MAX_RECORDS];
  logic [dqs_pkg::TAG_W-1:0]   held_tag [dqs_pkg::MAX_RECORDS];
  logic [2*dqs_pkg::IDX_W-1:0] range_stack [dqs_pkg::STACK_DEPTH];
  int                          held_count = 0;
  int                          depth = 0;
  sorted_record_t              sorted_queue [$];

  function automatic void swap_records(input int a, input int b);
    logic [dqs_pkg::KEY_W-1:0] k;
    logic [dqs_pkg::TAG_W-1:0] t;
    k           = held_key[a];
    t           = held_tag[a];
    held_key[a] = held_key[b];
    held_tag[a] = held_tag[b];
    held_key[b] = k;
    held_tag[b] = t;
  endfunction

  function automatic void push_range(input int lo, input int hi);
    if (depth < dqs_pkg::STACK_DEPTH) begin
      range_stack[depth] = {lo[dqs_pkg::IDX_W-1:0], hi[dqs_pkg::IDX_W-1:0]};
      depth++;
    end
  endfunction

  // Lomuto partitioning with the last element as pivot; keys >= pivot go left,
  // so the order of equal keys follows the quicksort exactly.
  function automatic void sort_descending(input int n);
    int                          lo;
    int                          hi;
    int                          place;
    int                          j;
    logic [dqs_pkg::KEY_W-1:0]   pivot;
    logic [2*dqs_pkg::IDX_W-1:0] entry;
    depth = 0;
    if (n < 2) return;
    push_range(0, n - 1);
    while (depth > 0) begin
      depth--;
      entry = range_stack[depth];
      lo    = int'(entry[2*dqs_pkg::IDX_W-1:dqs_pkg::IDX_W]);
      hi    = int'(entry[dqs_pkg::IDX_W-1:0]);
      if (lo >= hi || hi >= n) continue;
      pivot = held_key[hi];
      place = lo;
      for (j = lo; j < hi; j++) begin
        if (held_key[j] >= pivot) begin
          swap_records(place, j);
          place++;
        end
      end
      swap_records(place, hi);
      if (place + 1 < hi) push_range(place + 1, hi);
      if (place > lo + 1) push_range(lo, place - 1);
    end
  endfunction

  always @(posedge clk) begin
    sorted_record_t want;
    sorted_record_t got;
    int             errs;
    int             k;
    errs = 0;
    if (rst) begin
      held_count = 0;
      sorted_queue.delete();
    end else begin
      // Results are compared before the request of this edge is taken in;
      // no result can stem from a request accepted at the same edge.
      if (strobe) begin
        got = '{sorted_frequency, sorted_tag, end_of_run};
        if (sorted_queue.size() == 0) begin
          $display("%0t: expected no result, got freq=%h tag=%h last=%b", $time,
                   got.freq, got.id, got.last);
          errs++;
        end else begin
          want = sorted_queue.pop_front();
          if (got !== want) begin
            $display("%0t: expected freq=%h tag=%h last=%b, got freq=%h tag=%h last=%b",
                     $time, want.freq, want.id, want.last, got.freq, got.id, got.last);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        if (held_count < dqs_pkg::MAX_RECORDS) begin
          held_key[held_count] = frequency;
          held_tag[held_count] = tag;
          held_count++;
        end
        if (final_record) begin
          sort_descending(held_count);
          for (k = 0; k < held_count; k++) begin
            sorted_queue.push_back('{held_key[k], held_tag[k], k == held_count - 1});
          end
          held_count = 0;
        end
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= sorted_queue.size();
  end

endmodule

// ===== bench/descending_quicksort_engine_test.sv =====
`timescale 1ns / 100ps

module descending_quicksort_engine_test;

  // The slowest legal run is a full store of equal or descending keys, which
  // swaps at every scan step; everything else is small. The limit is many
  // times the slowest run.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 98;
  localparam int DRAIN_CYCLES = 64;

  // How the keys of one random set are drawn.
  typedef enum int {
    KEYS_SPREAD,
    KEYS_TIES,
    KEYS_RAMP
  } key_pattern_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [dqs_pkg::KEY_W-1:0] frequency = '0;
  logic [dqs_pkg::TAG_W-1:0] tag = '0;
  logic                      final_record = 1'b0;
  logic                      strobe;
  logic [dqs_pkg::KEY_W-1:0] sorted_frequency;
  logic [dqs_pkg::TAG_W-1:0] sorted_tag;
  logic                      end_of_run;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int idle_pct = 24;
  int random_sent = 0;

  always #2 clk = ~clk;

  descending_quicksort_engine uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .frequency        (frequency),
    .tag              (tag),
    .final_record     (final_record),
    .strobe           (strobe),
    .sorted_frequency (sorted_frequency),
    .sorted_tag       (sorted_tag),
    .end_of_run       (end_of_run)
  );

  dqs_sort_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .frequency        (frequency),
    .tag              (tag),
    .final_record     (final_record),
    .strobe           (strobe),
    .sorted_frequency (sorted_frequency),
    .sorted_tag       (sorted_tag),
    .end_of_run       (end_of_run),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("descending_quicksort_engine: mismatch");
      $finish;
    end
  end

  // Sends one request. The sender first idles a random number of cycles at the
  // current idle rate, then holds start high until an edge sees busy low. When
  // no idle cycle is drawn, start simply stays high into the next request.
  task automatic send_request(input logic [dqs_pkg::KEY_W-1:0] key,
                              input logic [dqs_pkg::TAG_W-1:0] id,
                              input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    frequency    <= key;
    tag          <= id;
    final_record <= last;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until the checker has seen every result it expects.
  // The count is sampled only after an edge, so an update at the edge that
  // accepted the last request is always seen.
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One set of random records, the last one flagged final. The idle rate moves
  // through three phases as the random part advances: light idling, heavy
  // idling, then none at all.
  task automatic send_random_set(input int size, input key_pattern_t pattern);
    logic [dqs_pkg::KEY_W-1:0] key;
    int                        base;
    int                        i;
    base = $urandom_range(0, 16'hFFFF);
    for (i = 0; i < size; i++) begin
      case (pattern)
        KEYS_SPREAD: key = dqs_pkg::KEY_W'($urandom);
        // Only three distinct keys, so ties are frequent.
        KEYS_TIES: key = dqs_pkg::KEY_W'(base + $urandom_range(0, 2));
        // Ascending keys make every partition as lopsided as it can be.
        default: key = dqs_pkg::KEY_W'(base + i);
      endcase
      if (random_sent < 50) idle_pct = 24;
      else if (random_sent < 75) idle_pct = 58;
      else idle_pct = 0;
      send_request(key, dqs_pkg::TAG_W'($urandom), i == size - 1);
      random_sent++;
    end
  endtask

  initial begin
    int           i;
    int           size;
    key_pattern_t pattern;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Single-record sets pass through unchanged, at both key and tag extremes.
    send_request(16'hFFFF, 16'h0000, 1'b1);
    send_request(16'h0000, 16'hFFFF, 1'b1);
    // Two-record sets: out of order, already in order, and a tie.
    send_request(16'h0000, 16'h0001, 1'b0);
    send_request(16'hFFFF, 16'h0002, 1'b1);
    send_request(16'hFFFF, 16'h0003, 1'b0);
    send_request(16'h0000, 16'h0004, 1'b1);
    send_request(16'h1234, 16'h0005, 1'b0);
    send_request(16'h1234, 16'h0006, 1'b1);
    // All keys equal: the tags show the order that quicksort leaves ties in.
    for (i = 0; i < 4; i++) begin
      send_request(16'h8000, dqs_pkg::TAG_W'(16'h0010 + i), i == 3);
    end
    // Ascending and descending runs.
    for (i = 0; i < 5; i++) begin
      send_request(dqs_pkg::KEY_W'(16'h7FFE + i), dqs_pkg::TAG_W'(16'h0020 + i), i == 4);
    end
    for (i = 0; i < 5; i++) begin
      send_request(dqs_pkg::KEY_W'(16'hFFF0 - i), dqs_pkg::TAG_W'(16'h0030 + i), i == 4);
    end
    pause_until_drained();

    // Store overflow: 64 records fill the store, the 65th (not final) and the
    // 66th (final) are dropped, and the full store is still sorted and sent.
    send_random_set(66, key_pattern_t'($urandom_range(0, 2)));
    pause_until_drained();

    // Mostly small sets keep the sort short; a few medium ones go deeper.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) pause_until_drained();
      size    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if (size > RANDOM_ITEMS - random_sent) size = RANDOM_ITEMS - random_sent;
      pattern = key_pattern_t'($urandom_range(0, 2));
      send_random_set(size, pattern);
    end

    // Wait for every expected result, then a while longer so that any stray
    // result still shows up before the verdict.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("descending_quicksort_engine: match");
    end else begin
      $display("descending_quicksort_engine: mismatch");
    end
    $finish;
  end

endmodule
